// ===== rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CMD_W-1:0]          op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/deq_front.sv =====
`default_nettype none

module deq_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [deq_pkg::CMD_W-1:0]           i_command,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]  i_push_value,
    output logic                                     o_cmd_valid,
    output deq_pkg::t_cmd                            o_cmd,
    input  wire logic                                i_cmd_take
);

    localparam int QD   = deq_pkg::QUEUE_DEPTH;
    localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC_W = $clog2(QD + 1);

    deq_pkg::t_cmd    r_q [QD];
    logic [QP_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0]  r_cnt, n_cnt;

    logic accept;
    logic enq;
    logic deq;

    assign o_in_stall  = (r_cnt == QC_W'(QD));
    assign accept      = i_in_valid && !o_in_stall;
    // drop undefined command codes: accepted, no result
    assign enq         = accept && (i_command <= deq_pkg::CMD_DUMP);
    assign o_cmd_valid = (r_cnt != '0);
    assign deq         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QD - 1)) ? '0 : r_wr_ptr + QP_W'(1);
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QD - 1)) ? '0 : r_rd_ptr + QP_W'(1);
        end
        if (enq && !deq) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (deq && !enq) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= '{op: i_command, value: i_push_value};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/deq_back.sv =====
`default_nettype none

module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cmd_valid,
    input  wire deq_pkg::t_cmd                       i_cmd,
    output logic                                     o_cmd_take,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [deq_pkg::VALUE_W-1:0]       o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]             o_status,
    output logic                                     o_last_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = deq_pkg::VALUE_W;
    localparam int SW = deq_pkg::STATUS_W;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [VW-1:0]  r_mem [DEPTH];
    logic [VW-1:0]  r_rd_data;

    logic [AW-1:0]  r_front, n_front;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;

    // read stage
    logic           r_b_valid;
    logic           r_b_use_rd;
    logic [SW-1:0]  r_b_status;
    logic           r_b_last;

    // output register
    logic           r_out_valid;
    logic [VW-1:0]  r_out_value;
    logic [SW-1:0]  r_out_status;
    logic           r_out_last;

    logic           b_move;
    logic           adv_a;
    logic           full;
    logic           empty;
    logic [CW-1:0]  k_next;

    logic           we;
    logic [AW-1:0]  wa;
    logic           re;
    logic [AW-1:0]  ra;
    logic           load_b;
    logic           b_use_rd;
    logic [SW-1:0]  b_status;
    logic           b_last;
    logic           take;

    assign b_move = !r_out_valid || !i_out_stall;
    assign adv_a  = !r_b_valid || b_move;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);
    assign k_next = r_k + CW'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_k      = r_k;
        we       = 1'b0;
        wa       = '0;
        re       = 1'b0;
        ra       = '0;
        load_b   = 1'b0;
        b_use_rd = 1'b0;
        b_status = deq_pkg::ST_OK;
        b_last   = 1'b1;
        take     = 1'b0;
        if (i_cmd_valid && adv_a) begin
            load_b = 1'b1;
            take   = 1'b1;
            unique case (i_cmd.op)
                deq_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        b_status = deq_pkg::ST_FULL;
                    end else begin
                        n_front = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
                        we      = 1'b1;
                        wa      = n_front;
                        n_count = r_count + CW'(1);
                    end
                end
                deq_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        b_status = deq_pkg::ST_FULL;
                    end else begin
                        we      = 1'b1;
                        wa      = ring_pos(r_front, r_count);
                        n_count = r_count + CW'(1);
                    end
                end
                deq_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        b_status = deq_pkg::ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        ra       = r_front;
                        b_use_rd = 1'b1;
                        n_front  = ring_pos(r_front, CW'(1));
                        n_count  = r_count - CW'(1);
                    end
                end
                deq_pkg::CMD_POP_BACK: begin
                    if (empty) begin
                        b_status = deq_pkg::ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        ra       = ring_pos(r_front, r_count - CW'(1));
                        b_use_rd = 1'b1;
                        n_count  = r_count - CW'(1);
                    end
                end
                deq_pkg::CMD_DUMP: begin
                    if (empty) begin
                        b_status = deq_pkg::ST_EMPTY;
                    end else begin
                        re       = 1'b1;
                        ra       = ring_pos(r_front, r_k);
                        b_use_rd = 1'b1;
                        b_last   = (k_next == r_count);
                        // hold the dump command until its final entry
                        take     = b_last;
                        n_k      = b_last ? '0 : k_next;
                    end
                end
                default: begin
                    load_b = 1'b0;
                end
            endcase
        end
    end

    assign o_cmd_take = take;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= i_cmd.value;
        end
        if (re) begin
            r_rd_data <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_k     <= n_k;
            if (load_b) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_b) begin
            r_b_use_rd <= b_use_rd;
            r_b_status <= b_status;
            r_b_last   <= b_last;
        end
        if (b_move && r_b_valid) begin
            r_out_value  <= r_b_use_rd ? r_rd_data : '0;
            r_out_status <= r_b_status;
            r_out_last   <= r_b_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_last_result  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values held in a ring of DEPTH entries.
// Each input item carries a command: push front (0), push back (1), pop front
// (2), pop back (3) or dump (4); codes 5 to 7 are accepted and dropped with no
// result. A push yields one result with status ok or full, a pop yields the
// value or status empty, and a dump yields every stored entry from front to
// back with o_last_result set on the final one (an empty dump gives a single
// empty result). Push and pop items are carried out at one item per cycle
// while i_out_stall is low; a dump is paced by the single read port of the
// entry memory, which is walked one entry per cycle under the same condition.
// The accepting edge writes the item into the command queue; from there it
// moves into the memory read stage and then into the output register, which
// drives o_out_valid, and a stall on the result channel can hold it between
// steps. The entry memory needs no clearing after reset; only written entries
// are ever read.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // command channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [deq_pkg::CMD_W-1:0]           i_command,
    input  wire logic signed [deq_pkg::VALUE_W-1:0]  i_push_value,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [deq_pkg::VALUE_W-1:0]       o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]             o_status,
    output logic                                     o_last_result
);

    // classified commands waiting for the back end
    logic          cmd_valid;
    deq_pkg::t_cmd cmd;
    logic          cmd_take;

    // Front end: accept items, drop undefined codes, and buffer the rest in a
    // short queue so input stalls only when that queue is full.
    deq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    // Back end: own the ring pointers and the entry memory, carry out one
    // command step per cycle unless the result channel stalls, and hand results to the output register.
    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire

// ===== dv/tb_double_ended_queue.sv =====
`default_nettype none

module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RESET_CYCLES = 11;
    localparam int RAND_ITEMS   = 320;     // random commands, ignored codes not counted
    localparam int TAIL_ITEMS   = 40;      // last stretch of the run runs without idling
    localparam int SETTLE       = 12;      // a few times the three-stage result latency
    localparam int CYCLE_LIMIT  = 200000;

    // one command waiting to be sent; hold marks a pause until all results are back
    typedef struct {
        logic [CMD_W-1:0]          op;
        logic signed [VALUE_W-1:0] value;
        bit                        hold;
    } deq_cmd_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } deq_result_t;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic [CMD_W-1:0]          i_command      = CMD_PUSH_FRONT;
    logic signed [VALUE_W-1:0] i_push_value   = '0;
    logic                      i_out_stall    = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [VALUE_W-1:0] o_result_value;
    logic [STATUS_W-1:0]       o_status;
    logic                      o_last_result;

    deq_cmd_t    cmd_backlog[$];
    deq_result_t want_results[$];

    // shadow deque: ring of DEPTH entries, front position and entry count
    logic signed [VALUE_W-1:0] shadow_store[DEPTH];
    int                        shadow_front = 0;
    int                        shadow_count = 0;

    int error_count   = 0;
    int cycle_count   = 0;
    int rand_count    = 0;
    int results_seen  = 0;
    int full_seen     = 0;
    int empty_seen    = 0;
    int dump_entries  = 0;
    int op_count[8];
    int send_gap      = 0;
    int recv_gap      = 0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    task automatic add_expected(input logic signed [VALUE_W-1:0] value,
                                input logic [STATUS_W-1:0] status, input logic last);
        deq_result_t r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        want_results.push_back(r);
        if (status == ST_FULL) full_seen++;
        if (status == ST_EMPTY) empty_seen++;
    endtask

    // Apply one accepted command to the shadow deque and queue up what it must produce.
    task automatic predict_deque_results(input logic [CMD_W-1:0] op,
                                         input logic signed [VALUE_W-1:0] value);
        int k;
        op_count[op]++;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    add_expected('0, ST_FULL, 1'b1);
                end else begin
                    if (op == CMD_PUSH_FRONT) begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = value;
                    end else begin
                        shadow_store[(shadow_front + shadow_count) % DEPTH] = value;
                    end
                    shadow_count++;
                    add_expected('0, ST_OK, 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    add_expected('0, ST_EMPTY, 1'b1);
                end else begin
                    add_expected(shadow_store[shadow_front], ST_OK, 1'b1);
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    add_expected('0, ST_EMPTY, 1'b1);
                end else begin
                    add_expected(shadow_store[(shadow_front + shadow_count - 1) % DEPTH],
                                 ST_OK, 1'b1);
                    shadow_count--;
                end
            end
            CMD_DUMP: begin
                if (shadow_count == 0) begin
                    add_expected('0, ST_EMPTY, 1'b1);
                end else begin
                    // walk front to back, flag the final entry; contents stay put
                    for (k = 0; k < shadow_count; k++) begin
                        add_expected(shadow_store[(shadow_front + k) % DEPTH], ST_OK,
                                     (k == shadow_count - 1));
                    end
                    dump_entries += shadow_count;
                end
            end
            default: ;  // codes above dump are dropped: no result, no state change
        endcase
    endtask

    // Driver: hand the next item over at a rising edge, honoring the stall, random gaps and hold marks.
    always @(posedge i_clk) begin : drive_commands
        deq_cmd_t nxt;
        logic     next_valid;
        if (i_rst_n) begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_deque_results(i_command, i_push_value);
                next_valid = 1'b0;
            end
            // a stalled item keeps valid and payload untouched
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_backlog.size() > 0) begin
                    if (cmd_backlog[0].hold) begin
                        // hold off until the block has handed back every result
                        if (want_results.size() == 0) void'(cmd_backlog.pop_front());
                    end else if (cmd_backlog.size() > TAIL_ITEMS
                                 && $urandom_range(0, 6) == 0) begin
                        send_gap = $urandom_range(1, 3) - 1;
                    end else begin
                        nxt          = cmd_backlog.pop_front();
                        i_command    <= nxt.op;
                        i_push_value <= nxt.value;
                        next_valid   = 1'b1;
                    end
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Monitor: check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        deq_result_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (want_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d last %0d",
                                              o_result_value, o_status, o_last_result));
                end else begin
                    want = want_results.pop_front();
                    if (o_result_value !== want.value)
                        report_mismatch($sformatf("result_value %0d, expected %0d",
                                                  o_result_value, want.value));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_last_result !== want.last)
                        report_mismatch($sformatf("last_result %0d, expected %0d",
                                                  o_last_result, want.last));
                end
            end
            // stall in short bursts, never during the tail of the run
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else if (cmd_backlog.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(1, 3) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, want_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic signed [VALUE_W-1:0] value);
        deq_cmd_t c;
        c.op    = op;
        c.value = value;
        c.hold  = 1'b0;
        cmd_backlog.push_back(c);
        if (op <= CMD_DUMP) rand_count++;
    endtask

    task automatic queue_hold();
        deq_cmd_t c;
        c.op    = CMD_DUMP;
        c.value = '0;
        c.hold  = 1'b1;
        cmd_backlog.push_back(c);
    endtask

    // lean on the extremes now and then, otherwise any 32-bit pattern
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_push();
        return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [CMD_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    initial begin : stimulus
        int  n;
        int  r;
        bit  mid_hold_done;
        mid_hold_done = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;

        // directed: empty-queue corners, dropped codes, single-entry pops
        queue_cmd(CMD_DUMP, pick_value());
        queue_cmd(CMD_POP_FRONT, '1);
        queue_cmd(CMD_POP_BACK, '0);
        queue_cmd(CMD_DUMP + 3'd1, $urandom);
        queue_cmd(CMD_DUMP + 3'd2, $urandom);
        queue_cmd(CMD_DUMP + 3'd3, $urandom);
        queue_cmd(CMD_PUSH_FRONT, {1'b1, {(VALUE_W-1){1'b0}}});
        queue_cmd(CMD_POP_BACK, '0);
        queue_cmd(CMD_PUSH_BACK, {1'b0, {(VALUE_W-1){1'b1}}});
        queue_cmd(CMD_POP_FRONT, '0);
        // fill to capacity from both ends, bounce off the full check, dump it all
        for (n = 0; n < DEPTH; n++)
            queue_cmd((n % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                      (n % 3 == 0) ? ~VALUE_W'(n) : VALUE_W'(n) << 27);
        queue_cmd(CMD_PUSH_BACK, '1);
        queue_cmd(CMD_DUMP, '0);
        queue_hold();
        rand_count = 0;

        // random: fill runs, drain runs and mixed traffic
        while (rand_count < RAND_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(8, 20)) queue_cmd(pick_push(), pick_value());
                    queue_cmd(CMD_DUMP, $urandom);
                end
                1: begin
                    repeat ($urandom_range(3, 18)) queue_cmd(pick_pop(), $urandom);
                end
                default: begin
                    repeat ($urandom_range(5, 15)) begin
                        r = $urandom_range(0, 19);
                        if (r < 7)
                            queue_cmd(pick_push(), pick_value());
                        else if (r < 15)
                            queue_cmd(pick_pop(), $urandom);
                        else if (r < 18)
                            queue_cmd(CMD_DUMP, $urandom);
                        else
                            queue_cmd(CMD_DUMP + 3'($urandom_range(1, 3)), $urandom);
                    end
                end
            endcase
            if (!mid_hold_done && rand_count > RAND_ITEMS / 2) begin
                queue_hold();
                mid_hold_done = 1'b1;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every item to be taken, then for every result to drain
        while (cmd_backlog.size() != 0 || i_in_valid) @(posedge i_clk);
        while (want_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent push front %0d, push back %0d, pop front %0d, pop back %0d, dump %0d,",
                 op_count[CMD_PUSH_FRONT], op_count[CMD_PUSH_BACK], op_count[CMD_POP_FRONT],
                 op_count[CMD_POP_BACK], op_count[CMD_DUMP]);
        $display("dropped codes %0d; %0d results checked, %0d dumped entries, %0d full, %0d empty",
                 op_count[5] + op_count[6] + op_count[7], results_seen, dump_entries,
                 full_seen, empty_seen);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
